>>> sv/cmdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmdr_pkg
// Shared types and constants of the variable-length command ring allocator.
// ----------------------------------------------------------------------------
package cmdr_pkg;

  localparam int DEF_RING_SLOTS   = 1024;
  localparam int MIN_RING         = 16;
  localparam int RESET_RING_SIZE  = 1024;
  localparam int RESET_RESERVED   = 1;

  localparam int LEN_W = 11;
  localparam int OFS_W = 10;
  localparam int CNT_W = 11;
  localparam int RES_W = 10;
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED  = 1'b1;

  typedef enum logic {
    OP_RESERVE  = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [LEN_W-1:0] entry_slots;
    logic [OFS_W-1:0] entry_start;
  } cmd_req_t;

  typedef struct packed {
    logic             accepted;
    logic [OFS_W-1:0] placed_at;
    logic [OFS_W-1:0] pad_slots;
    logic [CNT_W-1:0] retired_count;
    logic [OFS_W-1:0] head_now;
    logic [OFS_W-1:0] tail_now;
  } cmd_rsp_t;

  typedef struct packed {
    logic len_we;
    logic done_we;
    logic done_wdata;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_PLACE,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_FINISH
  } seq_state_t;

endpackage
`default_nettype wire

>>> sv/cmdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmdr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/cmdr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmdr_seq
// Request sequencer: configuration, head/tail pointers, space check,
// entry placement and in-order tail walk over the entry RAMs.
// ----------------------------------------------------------------------------
module cmdr_seq
  import cmdr_pkg::*;
#(
  parameter int RING_SLOTS = DEF_RING_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]                cfg_data,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire cmd_req_t                        cmd,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output cmd_rsp_t                             res,
  output mem_ctl_t                             mem_ctl,
  output logic [$clog2(RING_SLOTS)-1:0]        mem_addr,
  output logic [LEN_W-1:0]                     len_wdata,
  output logic [$clog2(RING_SLOTS)-1:0]        rd_addr,
  input  wire logic [LEN_W-1:0]                len_rdata,
  input  wire logic                            done_rdata
);

  localparam int PW = $clog2(RING_SLOTS);
  localparam int AW = (((PW + 1) > LEN_W) ? (PW + 1) : LEN_W) + 1;
  localparam logic [AW-1:0] SIZE_MIN = AW'(MIN_RING);
  localparam logic [AW-1:0] SIZE_MAX = AW'(RING_SLOTS);
  localparam logic [AW-1:0] SIZE_RST =
    (RESET_RING_SIZE > RING_SLOTS) ? AW'(RING_SLOTS) : AW'(RESET_RING_SIZE);

  seq_state_t       state, state_next;
  logic [PW-1:0]    head, head_next;
  logic [PW-1:0]    tail, tail_next;
  logic [AW-1:0]    size;
  logic [RES_W-1:0] reserved;
  op_t              item_op;
  logic [LEN_W-1:0] item_slots;
  logic [OFS_W-1:0] item_start;
  logic [AW-1:0]    used, used_next;
  logic [AW-1:0]    aux, aux_next;
  logic [AW-1:0]    room_cap, room_cap_next;
  logic             start_ok, start_ok_next;
  logic             accepted, accepted_next;
  logic [PW-1:0]    placed, placed_next;
  logic [AW-1:0]    pad, pad_next;
  logic [CNT_W-1:0] count, count_next;

  logic [AW-1:0] head_x, tail_x, start_x, slots_x, res_x, len_x, cfg_x;
  logic [AW-1:0] avail, needed, sum;
  logic [PW-1:0] start_idx;
  logic          fit_ok;
  logic          take;

  assign head_x    = AW'(head);
  assign tail_x    = AW'(tail);
  assign start_x   = AW'(item_start);
  assign slots_x   = AW'(item_slots);
  assign res_x     = AW'(reserved);
  assign len_x     = AW'(len_rdata);
  assign cfg_x     = AW'(cfg_data);
  assign start_idx = start_x[PW-1:0];
  assign take      = cmd_valid && !cmd_stall;

  assign avail  = (room_cap > used) ? room_cap - used : '0;
  assign needed = (aux >= slots_x) ? slots_x : slots_x + aux;
  assign fit_ok = (item_slots != '0) && (avail >= needed);
  assign sum    = (state == ST_WALK_EV) ? tail_x + len_x : head_x + slots_x;

  assign rd_addr = tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      size     <= SIZE_RST;
      reserved <= RES_W'(RESET_RESERVED);
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      if (cfg_we && cfg_index == CFG_RING_SIZE) begin
        head <= '0;
        tail <= '0;
        if (cfg_x < SIZE_MIN) begin
          size <= SIZE_MIN;
        end else if (cfg_x > SIZE_MAX) begin
          size <= SIZE_MAX;
        end else begin
          size <= cfg_x;
        end
      end
      if (cfg_we && cfg_index == CFG_RESERVED) begin
        reserved <= cfg_data[RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_op    <= cmd.operation;
      item_slots <= cmd.entry_slots;
      item_start <= cmd.entry_start;
    end
    used     <= used_next;
    aux      <= aux_next;
    room_cap <= room_cap_next;
    start_ok <= start_ok_next;
    accepted <= accepted_next;
    placed   <= placed_next;
    pad      <= pad_next;
    count    <= count_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    used_next     = used;
    aux_next      = aux;
    room_cap_next = room_cap;
    start_ok_next = start_ok;
    accepted_next = accepted;
    placed_next   = placed;
    pad_next      = pad;
    count_next    = count;
    cmd_stall     = 1'b1;
    res_valid     = 1'b0;
    mem_ctl       = '0;
    mem_addr      = head;
    len_wdata     = item_slots;

    case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          accepted_next = 1'b0;
          placed_next   = '0;
          pad_next      = '0;
          count_next    = '0;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        used_next = (head_x >= tail_x) ? head_x - tail_x : head_x + size - tail_x;
        if (item_op == OP_RESERVE) begin
          aux_next      = size - head_x;
          room_cap_next = (size > res_x) ? size - res_x : '0;
        end else begin
          aux_next      = (start_x >= tail_x) ? start_x - tail_x : start_x + size - tail_x;
          start_ok_next = (head != tail) && (start_x < size);
        end
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = ST_FINISH;
        if (item_op == OP_RESERVE) begin
          if (fit_ok && aux < slots_x) begin
            mem_ctl.len_we     = 1'b1;
            mem_ctl.done_we    = 1'b1;
            mem_ctl.done_wdata = 1'b1;
            len_wdata          = LEN_W'(aux);
            pad_next           = aux;
            head_next          = '0;
            state_next         = ST_PLACE;
          end else if (fit_ok) begin
            mem_ctl.len_we  = 1'b1;
            mem_ctl.done_we = 1'b1;
            placed_next     = head;
            accepted_next   = 1'b1;
            head_next       = (sum == size) ? '0 : sum[PW-1:0];
          end
        end else if (start_ok && aux < used) begin
          mem_ctl.done_we    = 1'b1;
          mem_ctl.done_wdata = 1'b1;
          mem_addr           = start_idx;
          accepted_next      = 1'b1;
          state_next         = ST_WALK_RD;
        end
      end
      ST_PLACE: begin
        mem_ctl.len_we  = 1'b1;
        mem_ctl.done_we = 1'b1;
        placed_next     = head;
        accepted_next   = 1'b1;
        head_next       = slots_x[PW-1:0];
        state_next      = ST_FINISH;
      end
      ST_WALK_RD: begin
        used_next  = (head_x >= tail_x) ? head_x - tail_x : head_x + size - tail_x;
        state_next = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        if (done_rdata && len_rdata != '0 && len_x <= used) begin
          tail_next  = (sum >= size) ? PW'(sum - size) : sum[PW-1:0];
          count_next = count + 1'b1;
          state_next = ST_WALK_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.accepted      = accepted;
    res.placed_at     = OFS_W'(placed);
    res.pad_slots     = OFS_W'(pad);
    res.retired_count = count;
    res.head_now      = OFS_W'(head);
    res.tail_now      = OFS_W'(tail);
  end

`ifndef SYNTHESIS
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    AW'(head) < size) else $error("head outside ring");

  a_tail_in_ring: assert property (@(posedge clk) disable iff (rst)
    AW'(tail) < size) else $error("tail outside ring");

  a_retire_only_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && count != '0) |-> item_op == OP_COMPLETE)
    else $error("reserve retired entries");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_EV) |-> $past(state) == ST_WALK_RD)
    else $error("walk evaluated without a read");

  a_place_after_pad: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLACE) |-> (head == '0 && pad != '0))
    else $error("placement after pad with bad head");
`endif

endmodule
`default_nettype wire

>>> sv/variable_entry_command_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// variable_entry_command_ring
// Circular allocator of variable-length command entries with in-order
// retirement.
// ----------------------------------------------------------------------------
// One request is processed at a time, and every request produces exactly one
// response. A reserve goes through the calc, check and finish states to the
// response register, with a place state before finish when a wrap pad entry
// is written first. An ignored complete goes through calc, check and finish;
// one that applies walks the tail between check and finish, with a read and an
// evaluate state for each entry it looks at, through the entry RAMs' single
// registered read port. Requests are taken only in the idle state, so the next
// request is accepted in the cycle after the response is handed over. A result
// waiting in the response register does not block the next request, but the
// sequencer holds its final result until the register is free. Entry RAMs
// need no clearing pass after reset. Writing ring_size empties the ring.
// ----------------------------------------------------------------------------
module variable_entry_command_ring
  import cmdr_pkg::*;
#(
  parameter int RING_SLOTS = DEF_RING_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire cmd_req_t             cmd,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output cmd_rsp_t                  rsp
);

  localparam int PW = $clog2(RING_SLOTS);

  mem_ctl_t         mem_ctl;
  logic [PW-1:0]    mem_addr;
  logic [PW-1:0]    rd_addr;
  logic [LEN_W-1:0] len_wdata;
  logic [LEN_W-1:0] len_rdata;
  logic             done_rdata;
  logic             res_valid;
  logic             res_ready;
  cmd_rsp_t         res;

  assign res_ready = !rsp_valid || !rsp_stall;

  cmdr_seq #(
    .RING_SLOTS(RING_SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .len_wdata  (len_wdata),
    .rd_addr    (rd_addr),
    .len_rdata  (len_rdata),
    .done_rdata (done_rdata)
  );

  cmdr_ram #(
    .WIDTH(LEN_W),
    .DEPTH(RING_SLOTS)
  ) u_len_ram (
    .clk     (clk),
    .we      (mem_ctl.len_we),
    .wr_addr (mem_addr),
    .wr_data (len_wdata),
    .rd_addr (rd_addr),
    .rd_data (len_rdata)
  );

  cmdr_ram #(
    .WIDTH(1),
    .DEPTH(RING_SLOTS)
  ) u_done_ram (
    .clk     (clk),
    .we      (mem_ctl.done_we),
    .wr_addr (mem_addr),
    .wr_data (mem_ctl.done_wdata),
    .rd_addr (rd_addr),
    .rd_data (done_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

>>> test/variable_entry_command_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// variable_entry_command_ring_tb
// Self-checking bench for the command ring allocator. A behavioral ring
// model predicts every response from the accepted requests and the register
// writes. Directed requests hit the corner cases first. Random traffic
// follows, mostly reserves and in-place completes of live entries under
// several ring settings; all runs but the last idle both channels at random.
// ----------------------------------------------------------------------------
module variable_entry_command_ring_tb;
  import cmdr_pkg::*;

  localparam int MAX_SHOWN = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RING_SIZE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_req_t             cmd = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  cmd_rsp_t             rsp;

  variable_entry_command_ring u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Ring model state
  int unsigned      ring_size_reg = RESET_RING_SIZE;
  int unsigned      reserve_margin = RESET_RESERVED;
  int unsigned      pred_head = 0;
  int unsigned      pred_tail = 0;
  logic [LEN_W-1:0] slot_len [DEF_RING_SLOTS];
  bit               slot_done [DEF_RING_SLOTS];

  cmd_rsp_t    expected_rsps[$];
  cmd_rsp_t    last_pred;
  cmd_rsp_t    want_rsp;
  int unsigned live_starts[$];
  int          mismatches = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;

  function automatic int unsigned live_size();
    if (ring_size_reg < MIN_RING) return MIN_RING;
    if (ring_size_reg > DEF_RING_SLOTS) return DEF_RING_SLOTS;
    return ring_size_reg;
  endfunction

  function automatic int unsigned span(int unsigned from, int unsigned to, int unsigned size);
    return (to >= from) ? to - from : to + size - from;
  endfunction

  function automatic cmd_rsp_t ring_predict(cmd_req_t r);
    int unsigned size, slots, start, room_cap, used, avail, to_end, needed, len, steps;
    bit          walking;
    cmd_rsp_t    res;
    size = live_size();
    slots = 32'(r.entry_slots);
    start = 32'(r.entry_start);
    res = '0;
    if (r.operation == OP_RESERVE) begin
      room_cap = (size > reserve_margin) ? size - reserve_margin : 0;
      used = span(pred_tail, pred_head, size);
      avail = (room_cap > used) ? room_cap - used : 0;
      to_end = size - pred_head;
      needed = (to_end >= slots) ? slots : slots + to_end;
      if (slots != 0 && avail >= needed) begin
        if (to_end < slots) begin
          res.pad_slots = OFS_W'(to_end);
          slot_len[pred_head] = LEN_W'(to_end);
          slot_done[pred_head] = 1'b1;
          pred_head = 0;
        end
        res.placed_at = OFS_W'(pred_head);
        slot_len[pred_head] = LEN_W'(slots);
        slot_done[pred_head] = 1'b0;
        pred_head = (pred_head + slots) % size;
        res.accepted = 1'b1;
      end
    end else if (pred_tail != pred_head && start < size &&
                 span(pred_tail, start, size) < span(pred_tail, pred_head, size)) begin
      slot_done[start] = 1'b1;
      res.accepted = 1'b1;
      walking = 1'b1;
      steps = 0;
      while (walking && steps < DEF_RING_SLOTS) begin
        steps++;
        if (pred_tail == pred_head || !slot_done[pred_tail]) begin
          walking = 1'b0;
        end else begin
          len = 32'(slot_len[pred_tail]);
          if (len == 0 || len > span(pred_tail, pred_head, size)) begin
            walking = 1'b0;
          end else begin
            pred_tail = (pred_tail + len) % size;
            res.retired_count = res.retired_count + 1'b1;
          end
        end
      end
    end
    res.head_now = OFS_W'(pred_head);
    res.tail_now = OFS_W'(pred_tail);
    return res;
  endfunction

  function automatic string rsp_str(cmd_rsp_t r);
    return $sformatf("acc=%0d at=%0d pad=%0d ret=%0d head=%0d tail=%0d", r.accepted,
                     r.placed_at, r.pad_slots, r.retired_count, r.head_now, r.tail_now);
  endfunction

  function automatic void log_error(string msg);
    if (mismatches < MAX_SHOWN) $display("%t ERROR %s", $realtime, msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        log_error({"unexpected response: ", rsp_str(rsp)});
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp.accepted !== want_rsp.accepted || rsp.placed_at !== want_rsp.placed_at ||
            rsp.pad_slots !== want_rsp.pad_slots ||
            rsp.retired_count !== want_rsp.retired_count ||
            rsp.head_now !== want_rsp.head_now || rsp.tail_now !== want_rsp.tail_now) begin
          log_error({"expected ", rsp_str(want_rsp), " got ", rsp_str(rsp)});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      rsp_stall <= 1'b1;
      stall_left = $urandom_range(11, 0);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_cmd(input op_t op, input int unsigned slots, input int unsigned start);
    cmd_req_t r;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    r.operation = op;
    r.entry_slots = LEN_W'(slots);
    r.entry_start = OFS_W'(start);
    cmd <= r;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    last_pred = ring_predict(r);
    expected_rsps.push_back(last_pred);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RING_SIZE) begin
      ring_size_reg = 32'(value);
      pred_head = 0;
      pred_tail = 0;
      live_starts.delete();
    end else begin
      reserve_margin = 32'(value[RES_W-1:0]);
    end
  endtask

  task automatic random_item(input int unsigned max_len);
    int unsigned size, pick, k, slots;
    size = live_size();
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_cmd(OP_COMPLETE, $urandom_range(2047), $urandom_range(1023));
    end else if (pick < 8) begin
      slots = $urandom_range(1) ? 0 : $urandom_range(2047, size + 1);
      send_cmd(OP_RESERVE, slots, $urandom_range(1023));
    end else if (live_starts.size() != 0 && (pick < 45 || live_starts.size() > 24)) begin
      k = $urandom_range(live_starts.size() - 1);
      send_cmd(OP_COMPLETE, $urandom_range(2047), live_starts[k]);
      live_starts.delete(k);
    end else begin
      slots = ($urandom_range(19) == 0) ? $urandom_range(size, 1) : $urandom_range(max_len, 1);
      send_cmd(OP_RESERVE, slots, $urandom_range(1023));
      if (last_pred.accepted) live_starts.push_back(last_pred.placed_at);
      // a completely full ring reads as empty: drop what it held
      if (last_pred.head_now == last_pred.tail_now) live_starts.delete();
    end
  endtask

  task automatic run_random(input int n, input int unsigned ring,
                            input int unsigned margin, input int unsigned max_len,
                            input bit idle);
    write_reg(CFG_RING_SIZE, CFG_W'(ring));
    write_reg(CFG_RESERVED, CFG_W'(margin));
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        gap_pct = (!idle || $urandom_range(3) == 0) ? 0 : $urandom_range(50, 5);
        stall_pct = (!idle || $urandom_range(3) == 0) ? 0 : $urandom_range(50, 5);
      end
      if ($urandom_range(99) == 0) wait_idle();
      random_item(max_len);
    end
    wait_idle();
  endtask

  task automatic test_reset_ring();
    gap_pct = 20;
    stall_pct = 20;
    send_cmd(OP_COMPLETE, 0, 0);
    send_cmd(OP_RESERVE, 0, 0);
    send_cmd(OP_RESERVE, 2047, 1023);
    send_cmd(OP_RESERVE, 1024, 0);
    send_cmd(OP_RESERVE, 1023, 0);
    send_cmd(OP_COMPLETE, 1, 5);
    send_cmd(OP_COMPLETE, 1, 1023);
    send_cmd(OP_COMPLETE, 1, 0);
    send_cmd(OP_RESERVE, 3, 0);
    send_cmd(OP_COMPLETE, 3, 0);
  endtask

  task automatic test_small_ring_full();
    write_reg(CFG_RING_SIZE, CFG_W'(16));
    write_reg(CFG_RESERVED, CFG_W'(0));
    send_cmd(OP_RESERVE, 16, 0);
    send_cmd(OP_COMPLETE, 0, 0);
    send_cmd(OP_RESERVE, 5, 0);
    send_cmd(OP_RESERVE, 4, 0);
    send_cmd(OP_COMPLETE, 0, 5);
    send_cmd(OP_COMPLETE, 2047, 1023);
    send_cmd(OP_COMPLETE, 0, 0);
    send_cmd(OP_RESERVE, 7, 0);
    send_cmd(OP_RESERVE, 9, 0);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_RING_SIZE, CFG_W'(0));
    write_reg(CFG_RESERVED, CFG_W'(1023));
    send_cmd(OP_RESERVE, 1, 0);
    send_cmd(OP_COMPLETE, 0, 0);
    write_reg(CFG_RING_SIZE, CFG_W'(2047));
    send_cmd(OP_RESERVE, 1, 0);
    send_cmd(OP_RESERVE, 1, 0);
    send_cmd(OP_COMPLETE, 0, 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random(290, 1024, 1, 40, 1'b1);
    run_random(290, 16, 0, 8, 1'b1);
    run_random(280, 100, 7, 20, 1'b1);
    run_random(120, 2047, 1023, 3, 1'b1);
    run_random(190, 1500, 512, 64, 1'b1);
  endtask

  task automatic test_unthrottled_tail();
    run_random(260, 37, 3, 10, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_ring();
    test_small_ring_full();
    test_config_extremes();
    test_random_traffic();
    test_unthrottled_tail();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("variable_entry_command_ring_tb OK");
    end else begin
      $display("variable_entry_command_ring_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("variable_entry_command_ring_tb NOT OK");
    $finish;
  end

endmodule
